[rtl/dilp_pkg.sv]
`timescale 1ns / 1ps

package dilp_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;

   typedef enum logic [2:0] {
      PH_LEAD       = 3'd0,
      PH_SIGN       = 3'd1,
      PH_DIGITS     = 3'd2,
      PH_TRAIL      = 3'd3,
      PH_SIGN_BLANK = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_DIGITS = 2'd1,
      ST_BAD_CHAR  = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   // one classified character
   typedef struct packed {
      logic       is_blank;
      logic       is_digit;
      logic       is_sign;
      logic       is_minus;
      logic [3:0] digit;
      logic       line_end;
   } class_type;

endpackage

[rtl/dilp_fifo.sv]
`timescale 1ns / 1ps

module dilp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = dilp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   import dilp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/dilp_front.sv]
`timescale 1ns / 1ps

module dilp_front #(
   parameter int DEPTH = dilp_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           char_code,
   input  logic                 line_end,
   input  logic                 push,
   output logic                 full,
   input  logic                 item_take,
   output dilp_pkg::class_type  item,
   output logic                 item_avail
);
   import dilp_pkg::*;

   localparam int CLASS_W = $bits(class_type);

   class_type          cls;
   logic [CLASS_W-1:0] head;
   logic               empty;

   always_comb begin
      cls.is_blank = (char_code == CHAR_SPACE) || (char_code == CHAR_TAB);
      cls.is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      cls.is_sign  = (char_code == CHAR_PLUS) || (char_code == CHAR_MINUS);
      cls.is_minus = (char_code == CHAR_MINUS);
      cls.digit    = 4'(char_code - CHAR_ZERO);
      cls.line_end = line_end;
   end

   dilp_fifo #(
      .WIDTH(CLASS_W),
      .DEPTH(DEPTH)
   ) u_class_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (cls),
      .full    (full),
      .rd_en   (item_take),
      .rd_data (head),
      .empty   (empty)
   );

   assign item       = class_type'(head);
   assign item_avail = !empty;

endmodule

[rtl/dilp_back.sv]
`timescale 1ns / 1ps

module dilp_back #(
   parameter int VALUE_BITS = dilp_pkg::VALUE_BITS_DEF,
   parameter int DEPTH      = dilp_pkg::QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dilp_pkg::class_type          item,
   input  logic                         item_avail,
   output logic                         item_take,
   output logic signed [VALUE_BITS-1:0] int_value,
   output logic                         is_valid,
   output dilp_pkg::status_type         parse_status,
   output logic                         empty,
   input  logic                         pop
);
   import dilp_pkg::*;

   localparam int SUM_W = VALUE_BITS + 4;
   localparam int RES_W = VALUE_BITS + 3;
   localparam logic [SUM_W-1:0] LIMIT_EXT = {{4{1'b0}}, 1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] LIMIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

   phase_type             phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  ovf_ff, ovf_in;
   logic                  bad_ff, bad_in;

   logic [SUM_W-1:0]      mag_ext, sum;
   logic                  add_ok;
   logic                  res_full;
   logic                  has_digits, out_range;
   status_type            status;
   logic [VALUE_BITS-1:0] value;
   logic [RES_W-1:0]      res_wr, res_rd;

   assign mag_ext = {4'b0, mag_ff};
   assign sum     = (mag_ext << 3) + (mag_ext << 1) + {{(SUM_W-4){1'b0}}, item.digit};
   assign add_ok  = (sum <= LIMIT_EXT);

   assign item_take = item_avail && (!item.line_end || !res_full);

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      ovf_in   = ovf_ff;
      bad_in   = bad_ff;
      if (!bad_ff) begin
         case (phase_ff)
            PH_SIGN: begin
               if (item.is_blank) begin
                  phase_in = PH_SIGN_BLANK;
               end else if (item.is_digit) begin
                  phase_in = PH_DIGITS;
               end else begin
                  bad_in = 1'b1;
               end
            end
            PH_DIGITS: begin
               if (item.is_blank) begin
                  phase_in = PH_TRAIL;
               end else if (!item.is_digit) begin
                  bad_in = 1'b1;
               end
            end
            PH_TRAIL, PH_SIGN_BLANK: begin
               if (!item.is_blank) begin
                  bad_in = 1'b1;
               end
            end
            default: begin
               if (item.is_blank) begin
                  phase_in = PH_LEAD;
               end else if (item.is_sign) begin
                  neg_in   = item.is_minus;
                  phase_in = PH_SIGN;
               end else if (item.is_digit) begin
                  phase_in = PH_DIGITS;
               end else begin
                  bad_in = 1'b1;
               end
            end
         endcase
         // digit accumulation, sticky overflow past the limit
         if (item.is_digit && phase_in == PH_DIGITS && !ovf_ff) begin
            if (add_ok) begin
               mag_in = sum[VALUE_BITS-1:0];
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      has_digits = (phase_in == PH_DIGITS) || (phase_in == PH_TRAIL);
      out_range  = ovf_in || (!neg_in && mag_in == LIMIT);
      if (bad_in) begin
         status = ST_BAD_CHAR;
      end else if (!has_digits) begin
         status = ST_NO_DIGITS;
      end else if (out_range) begin
         status = ST_RANGE;
      end else begin
         status = ST_OK;
      end
      value = '0;
      if (status == ST_OK) begin
         value = neg_in ? (~mag_in + 1'b1) : mag_in;
      end
      res_wr = {value, (status == ST_OK), status};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
         ovf_ff   <= 1'b0;
         bad_ff   <= 1'b0;
      end else if (item_take) begin
         if (item.line_end) begin
            phase_ff <= PH_LEAD;
            neg_ff   <= 1'b0;
            mag_ff   <= '0;
            ovf_ff   <= 1'b0;
            bad_ff   <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            mag_ff   <= mag_in;
            ovf_ff   <= ovf_in;
            bad_ff   <= bad_in;
         end
      end
   end

   dilp_fifo #(
      .WIDTH(RES_W),
      .DEPTH(DEPTH)
   ) u_result_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (item_take && item.line_end),
      .wr_data (res_wr),
      .full    (res_full),
      .rd_en   (pop),
      .rd_data (res_rd),
      .empty   (empty)
   );

   assign int_value    = res_rd[RES_W-1:3];
   assign is_valid     = res_rd[2];
   assign parse_status = status_type'(res_rd[1:0]);

endmodule

[rtl/decimal_integer_line_parser.sv]
`timescale 1ns / 1ps
// Path: class queue, back-end parse, result queue whose head drives rsp_.
// Throughput: one character per cycle while full is low; the back end parses
//   one per cycle, but stalls on a line end while the result queue is full.
// Reset: synchronous, active high; empties both queues and clears parse state.

module decimal_integer_line_parser #(
   parameter int VALUE_BITS = dilp_pkg::VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [7:0]                   req_char_code,
   input  logic                         req_line_end,
   input  logic                         push,
   output logic                         full,
   output logic signed [VALUE_BITS-1:0] rsp_int_value,
   output logic                         rsp_is_valid,
   output logic [1:0]                   rsp_parse_status,
   output logic                         empty,
   input  logic                         pop
);
   import dilp_pkg::*;

   class_type  item;
   logic       item_avail;
   logic       item_take;
   status_type status;

   dilp_front #(
      .DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .char_code  (req_char_code),
      .line_end   (req_line_end),
      .push       (push),
      .full       (full),
      .item_take  (item_take),
      .item       (item),
      .item_avail (item_avail)
   );

   dilp_back #(
      .VALUE_BITS(VALUE_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .item         (item),
      .item_avail   (item_avail),
      .item_take    (item_take),
      .int_value    (rsp_int_value),
      .is_valid     (rsp_is_valid),
      .parse_status (status),
      .empty        (empty),
      .pop          (pop)
   );

   assign rsp_parse_status = status;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import dilp_pkg::*;

   localparam int          IDLE_LIMIT  = 2000;
   localparam int          HOLD_CYCLES = 300;
   localparam logic [63:0] MAG_LIMIT   = 64'd1 << 31;

   typedef logic [7:0] line_type[$];

   typedef struct {
      logic signed [31:0] value;
      logic               valid;
      status_type         status;
   } parsed_number_type;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic [7:0]         req_char_code    = 8'h00;
   logic               req_line_end     = 1'b0;
   logic               push             = 1'b0;
   logic               pop              = 1'b0;
   logic               full;
   logic               empty;
   logic signed [31:0] rsp_int_value;
   logic               rsp_is_valid;
   logic [1:0]         rsp_parse_status;

   parsed_number_type expected_numbers[$];
   int                mismatches  = 0;
   int                chars_sent  = 0;
   int                hold_req    = 0;
   bit                idling      = 1'b1;

   // line parse state
   phase_type   line_phase = PH_LEAD;
   logic        line_neg   = 1'b0;
   logic [63:0] line_mag   = 64'd0;
   logic        line_ovf   = 1'b0;
   logic        line_bad   = 1'b0;

   decimal_integer_line_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_char_code    (req_char_code),
      .req_line_end     (req_line_end),
      .push             (push),
      .full             (full),
      .rsp_int_value    (rsp_int_value),
      .rsp_is_valid     (rsp_is_valid),
      .rsp_parse_status (rsp_parse_status),
      .empty            (empty),
      .pop              (pop)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic void accumulate_digit(logic [3:0] d);
      if (!line_ovf) begin
         if (line_mag > (MAG_LIMIT - d) / 10) line_ovf = 1'b1;
         else line_mag = line_mag * 10 + d;
      end
   endfunction

   function automatic void parse_char(logic [7:0] c, logic last);
      logic              blank;
      logic              digit;
      logic              sign;
      logic              has_digits;
      logic [7:0]        dv;
      logic [63:0]       signed_mag;
      parsed_number_type n;
      blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
      dv    = c - CHAR_ZERO;
      if (!line_bad) begin
         case (line_phase)
            PH_SIGN: begin
               if (blank) line_phase = PH_SIGN_BLANK;
               else if (digit) begin
                  accumulate_digit(dv[3:0]);
                  line_phase = PH_DIGITS;
               end else line_bad = 1'b1;
            end
            PH_DIGITS: begin
               if (digit) accumulate_digit(dv[3:0]);
               else if (blank) line_phase = PH_TRAIL;
               else line_bad = 1'b1;
            end
            PH_TRAIL, PH_SIGN_BLANK: begin
               if (!blank) line_bad = 1'b1;
            end
            default: begin
               if (blank) line_phase = PH_LEAD;
               else if (sign) begin
                  line_neg   = (c == CHAR_MINUS);
                  line_phase = PH_SIGN;
               end else if (digit) begin
                  accumulate_digit(dv[3:0]);
                  line_phase = PH_DIGITS;
               end else line_bad = 1'b1;
            end
         endcase
      end
      if (last) begin
         has_digits = (line_phase == PH_DIGITS) || (line_phase == PH_TRAIL);
         if (line_bad) n.status = ST_BAD_CHAR;
         else if (!has_digits) n.status = ST_NO_DIGITS;
         else if (line_ovf || (!line_neg && line_mag == MAG_LIMIT)) n.status = ST_RANGE;
         else n.status = ST_OK;
         n.valid    = (n.status == ST_OK);
         signed_mag = line_neg ? (64'd0 - line_mag) : line_mag;
         n.value    = n.valid ? signed_mag[31:0] : 32'sd0;
         expected_numbers.push_back(n);
         line_phase = PH_LEAD;
         line_neg   = 1'b0;
         line_mag   = 64'd0;
         line_ovf   = 1'b0;
         line_bad   = 1'b0;
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   task automatic send_char(logic [7:0] c, logic last);
      logic taken;
      req_char_code <= c;
      req_line_end  <= last;
      push          <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !full;
         @(posedge clock);
      end
      parse_char(c, last);
      chars_sent++;
      if (idling && $urandom_range(0, 7) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic send_line(line_type l);
      foreach (l[i]) send_char(l[i], i == l.size() - 1);
   endtask

   function automatic line_type text(string s);
      line_type l;
      foreach (s[i]) l.push_back(s[i]);
      return l;
   endfunction

   function automatic logic [7:0] random_blank();
      return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
   endfunction

   function automatic line_type random_line();
      line_type l;
      string    digits;
      int       kind;
      kind = $urandom_range(0, 9);
      if (kind == 8) begin
         repeat ($urandom_range(1, 6)) l.push_back(8'($urandom_range(0, 255)));
         return l;
      end
      if (kind == 9) begin
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 3))
               0: l.push_back(CHAR_SPACE);
               1: l.push_back(CHAR_TAB);
               2: l.push_back(CHAR_PLUS);
               default: l.push_back(CHAR_MINUS);
            endcase
         end
         return l;
      end
      repeat ($urandom_range(0, 2)) l.push_back(random_blank());
      case ($urandom_range(0, 2))
         1: l.push_back(CHAR_PLUS);
         2: l.push_back(CHAR_MINUS);
         default: ;
      endcase
      case ($urandom_range(0, 3))
         0: digits = $sformatf("%0d", $urandom_range(0, 9999));
         1: digits = $sformatf("%0d", $urandom);
         2: digits = $sformatf("%0d", 64'd2147483638 + $urandom_range(0, 20));
         default: digits = $sformatf("%0d%0d", $urandom_range(1, 999), $urandom);
      endcase
      if ($urandom_range(0, 5) == 0) digits = {"00", digits};
      foreach (digits[i]) l.push_back(digits[i]);
      repeat ($urandom_range(0, 2)) l.push_back(random_blank());
      if (kind == 6) l[$urandom_range(0, l.size() - 1)] = 8'($urandom_range(0, 255));
      if (kind == 7) l.insert($urandom_range(0, l.size()), random_blank());
      return l;
   endfunction

   task automatic test_basic_forms();
      send_line(text("0"));
      send_line(text("+7"));
      send_line(text("-0"));
      send_line(text("  -42\t"));
      send_line(text("\t+15  "));
      send_line(text(" "));
      send_line(text("-"));
      send_line(text("+ \t"));
   endtask

   task automatic test_range_edges();
      send_line(text("2147483647"));
      send_line(text("-2147483648"));
      send_line(text("2147483648"));
      send_line(text("-2147483649"));
      send_line(text("000000000012"));
      send_line(text("99999999999"));
   endtask

   task automatic test_bad_chars();
      send_line(text("- 5"));
      send_line(text("12 3"));
      send_line(text("+-1"));
      send_line(text("1a"));
      send_line(text("-x"));
      send_line(text("9999999999x"));
      send_line('{8'h00});
      send_line('{CHAR_ZERO + 8'd7, 8'h0D});
      send_line('{8'h0A});
      send_line('{8'hFF});
      send_line('{8'h80, CHAR_ZERO});
   endtask

   task automatic test_backpressure();
      int target;
      idling   = 1'b0;
      hold_req = HOLD_CYCLES;
      target   = chars_sent + 40;
      while (chars_sent < target) send_line(random_line());
      idling = 1'b1;
   endtask

   task automatic test_random_lines(int n_chars, bit with_idle);
      int target;
      idling = with_idle;
      target = chars_sent + n_chars;
      while (chars_sent < target) send_line(random_line());
   endtask

   initial begin
      int stall;
      stall = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_req > 0) begin
            stall    = hold_req;
            hold_req = 0;
         end
         if (stall == 0 && idling && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 13);
         if (stall > 0) begin
            pop <= 1'b0;
            stall--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin
      parsed_number_type n;
      forever begin
         @(negedge clock);
         if (!reset && pop && !empty) begin
            if (expected_numbers.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_int_value, 0);
            end else begin
               n = expected_numbers.pop_front();
               if (rsp_int_value !== n.value)
                  report_mismatch("int_value", rsp_int_value, n.value);
               if (rsp_is_valid !== n.valid)
                  report_mismatch("is_valid", rsp_is_valid, n.valid);
               if (rsp_parse_status !== n.status)
                  report_mismatch("parse_status", rsp_parse_status, n.status);
            end
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(negedge clock);
         if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      wait (!reset);
      @(posedge clock);
      test_basic_forms();
      test_range_edges();
      test_bad_chars();
      test_backpressure();
      test_random_lines(800, 1'b1);
      test_random_lines(150, 1'b0);
      push <= 1'b0;
      while (expected_numbers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/dilp_pkg.sv
rtl/dilp_fifo.sv
rtl/dilp_front.sv
rtl/dilp_back.sv
rtl/decimal_integer_line_parser.sv
tb/sv/tb_top.sv
